### rtl/triaxial_sample_validity_monitor_core_assert.svh
// Assertion macros for the triaxial sample validity monitor.
// Used by the top level only; needs a clk and an active-low rst_n in scope.
`ifndef TRIAXIAL_SAMPLE_VALIDITY_MONITOR_CORE_ASSERT_SVH
`define TRIAXIAL_SAMPLE_VALIDITY_MONITOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked property, ignored while reset is held.
`define SVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, also during reset.
`define SVM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SVM_ASSERT(lbl, prop, msg)
`define SVM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/svm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the triaxial sample validity monitor.
// No dependencies.
package svm_pkg;

  localparam int SAMPLE_W = 16;
  // compare width: covers a signed sample, its difference and a 16 bit limit
  localparam int CMP_W    = SAMPLE_W + 2;
  localparam int AXES     = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W     = 2;
  localparam int ABS_LIM_W  = 15;
  localparam int REL_LIM_W  = 16;
  localparam int PERSIST_W  = 8;
  localparam int INST_W     = 7;
  localparam int PERM_W     = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PKG_PERSIST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_PERSIST = 3'd4;

  localparam logic [MODE_W-1:0] MODE_FULL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DATA = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd2;

  localparam logic [ABS_LIM_W-1:0] ABS_LIMIT_RST   = 15'd2560;
  localparam logic [REL_LIM_W-1:0] REL_LIMIT_RST   = 16'd200;
  localparam logic [PERSIST_W-1:0] PKG_PERSIST_RST = 8'd20;
  localparam logic [PERSIST_W-1:0] DATA_PERSIST_RST = 8'd10;

  localparam logic [PERM_W-1:0] PERM_PKG_MASK = 12'h0DE0;
  localparam logic [PERM_W-1:0] PERM_X        = 12'h0100;
  localparam logic [PERM_W-1:0] PERM_Y        = 12'h0400;
  localparam logic [PERM_W-1:0] PERM_Z        = 12'h0800;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
    logic                       timeout;
    logic                       header_ok;
    logic                       checksum_ok;
    logic                       payload_ok;
    logic                       switchover;
  } svm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accepted_x;
    logic signed [SAMPLE_W-1:0] accepted_y;
    logic signed [SAMPLE_W-1:0] accepted_z;
    logic [INST_W-1:0]          instant_status;
    logic [PERM_W-1:0]          permanent_status;
    logic                       package_bad;
    logic                       reject_seen;
  } svm_out_t;

  // per-beat control shared by the axis checkers
  typedef struct packed {
    logic fire;
    logic full;
    logic data_only;
    logic pkt_bad;
  } svm_axis_ctl_t;

  typedef struct packed {
    logic abs_exceed;
    logic rate_exceed;
    logic replaced;
    logic fail_set;
  } svm_axis_stat_t;

  typedef struct packed {
    logic pkt_bad;
    logic pkg_fail;
  } svm_pkt_stat_t;

endpackage

### rtl/svm_pkt.sv
`timescale 1ns / 1ps
// Packet health check and bad-packet run counter.
// Depends on svm_pkg.
module svm_pkt
  import svm_pkg::*;
#(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic                 full,
  input  logic                 timeout,
  input  logic                 header_ok,
  input  logic                 checksum_ok,
  input  logic                 payload_ok,
  input  logic [PERSIST_W-1:0] persist,
  output svm_pkt_stat_t        stat
);

  localparam int RW = (COUNT_WIDTH > PERSIST_W) ? COUNT_WIDTH : PERSIST_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] run_r;
  logic [COUNT_WIDTH-1:0] run_nxt;
  logic [COUNT_WIDTH-1:0] run_inc;
  logic [RW-1:0]          run_ext;
  logic [RW-1:0]          inc_ext;
  logic [RW-1:0]          pers_ext;
  logic                   bad;

  assign bad      = full && (timeout || !header_ok || !checksum_ok || !payload_ok);
  assign run_inc  = (run_r == CNT_MAX) ? run_r : run_r + 1'b1;
  assign run_ext  = RW'(run_r);
  assign inc_ext  = RW'(run_inc);
  assign pers_ext = RW'(persist);

  always_comb begin
    run_nxt = run_r;
    if (bad) begin
      run_nxt = run_inc;
    end else if (run_ext < pers_ext) begin
      run_nxt = '0;
    end
  end

  assign stat.pkt_bad  = bad;
  assign stat.pkg_fail = bad && (inc_ext >= pers_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (fire) begin
      run_r <= run_nxt;
    end
  end

endmodule

### rtl/svm_axis.sv
`timescale 1ns / 1ps
// One axis: rate and absolute limit checks, last-good hold, violation run.
// Depends on svm_pkg.
module svm_axis
  import svm_pkg::*;
#(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  svm_axis_ctl_t              ctl,
  input  logic                       sw_hold,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [ABS_LIM_W-1:0]       abs_limit,
  input  logic [REL_LIM_W-1:0]       rel_limit,
  input  logic [PERSIST_W-1:0]       persist,
  output logic signed [SAMPLE_W-1:0] accepted,
  output svm_axis_stat_t             stat
);

  localparam int RW = (COUNT_WIDTH > PERSIST_W) ? COUNT_WIDTH : PERSIST_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic signed [SAMPLE_W-1:0] lg_r;
  logic [COUNT_WIDTH-1:0]     run_r;
  logic [COUNT_WIDTH-1:0]     run_nxt;
  logic [COUNT_WIDTH-1:0]     run_inc;
  logic                       flag_r;
  logic                       flag_nxt;

  logic signed [SAMPLE_W-1:0] sel;
  logic signed [CMP_W-1:0]    sel_ext;
  logic signed [CMP_W-1:0]    diff;
  logic signed [CMP_W-1:0]    mag;
  logic signed [CMP_W-1:0]    lim_pos;
  logic signed [CMP_W-1:0]    lim_neg;
  logic signed [CMP_W-1:0]    rel_ext;
  logic                       chk_en;
  logic                       abs_hit;
  logic                       replace;
  logic [RW-1:0]              run_ext;
  logic [RW-1:0]              inc_ext;
  logic [RW-1:0]              pers_ext;

  // bad packet: work on the held sample
  assign sel     = ctl.pkt_bad ? lg_r : sample;
  assign sel_ext = CMP_W'(sel);
  assign diff    = sel_ext - CMP_W'(lg_r);
  assign mag     = (diff < 0) ? -diff : diff;
  assign rel_ext = signed'({{(CMP_W-REL_LIM_W){1'b0}}, rel_limit});
  assign lim_pos = signed'({{(CMP_W-ABS_LIM_W){1'b0}}, abs_limit});
  assign lim_neg = -lim_pos;

  assign chk_en  = ctl.full || ctl.data_only;
  assign abs_hit = chk_en && ((sel_ext > lim_pos) || (sel_ext < lim_neg));

  // switchover leaves the flag as it was on a violation
  assign flag_nxt = abs_hit ? (sw_hold ? flag_r : 1'b1) : 1'b0;
  assign replace  = flag_nxt && ((ctl.full && !ctl.pkt_bad) || ctl.data_only);

  assign run_inc  = (run_r == CNT_MAX) ? run_r : run_r + 1'b1;
  assign run_ext  = RW'(run_r);
  assign inc_ext  = RW'(run_inc);
  assign pers_ext = RW'(persist);

  always_comb begin
    run_nxt = run_r;
    if (replace) begin
      run_nxt = run_inc;
    end else if (run_ext < pers_ext) begin
      run_nxt = '0;
    end
  end

  assign accepted         = replace ? lg_r : sel;
  assign stat.abs_exceed  = abs_hit;
  assign stat.rate_exceed = mag > rel_ext;
  assign stat.replaced    = replace;
  assign stat.fail_set    = replace && (inc_ext >= pers_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r   <= '0;
      run_r  <= '0;
      flag_r <= 1'b0;
    end else if (ctl.fire) begin
      lg_r   <= accepted;
      run_r  <= run_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

### rtl/triaxial_sample_validity_monitor_core.sv
`timescale 1ns / 1ps
// Top level of the triaxial sample validity monitor.
// Depends on svm_pkg, svm_pkt, svm_axis and the assertion macro header.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): one beat is one sensor frame,
//    three signed Q4.12 samples, four packet health flags and a switchover bit.
//  - Result channel (out_valid / out_stall / out_data): one beat per input beat,
//    in order: accepted samples, instant and sticky status, package_bad and
//    reject_seen.
//  - Config port (cfg_wr_en / cfg_index / cfg_data): single-cycle writes, only
//    while no beat is in flight.
//  - Path: a beat goes through the input register, then the result register,
//    before out_valid rises; a receiver stall can hold it in between.
//    Throughput: one beat per cycle while the receiver does not stall; the per-axis
//    compares and the last-good update sit in one stage between the two.
//  - Receiver stall: the result register holds; the input register still
//    fills, then in_stall rises until the result is taken. Nothing is dropped.
//  - Reset (rst_n low, synchronous): config registers back to defaults, last-good
//    samples, run counters and all sticky status cleared, both channels empty.
`include "triaxial_sample_validity_monitor_core_assert.svh"

module triaxial_sample_validity_monitor_core
  import svm_pkg::*;
#(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  svm_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output svm_out_t              out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // config registers
  logic [MODE_W-1:0]    mode_r;
  logic [ABS_LIM_W-1:0] abs_lim_r;
  logic [REL_LIM_W-1:0] rel_lim_r;
  logic [PERSIST_W-1:0] pkg_pers_r;
  logic [PERSIST_W-1:0] data_pers_r;

  // input stage and result stage
  logic     s1_valid_r;
  logic     s1_valid_nxt;
  svm_in_t  s1_data_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  svm_out_t out_data_r;
  svm_out_t out_data_nxt;

  logic out_ready;
  logic s1_fire;
  logic in_fire;

  // sticky status
  logic [PERM_W-1:0] perm_r;
  logic [PERM_W-1:0] perm_nxt;
  logic              reject_r;
  logic              reject_nxt;

  svm_pkt_stat_t              pkt_stat;
  svm_axis_ctl_t              axis_ctl;
  svm_axis_stat_t             ax_stat [AXES];
  logic signed [SAMPLE_W-1:0] ax_in   [AXES];
  logic signed [SAMPLE_W-1:0] ax_out  [AXES];
  logic                       ax_hold [AXES];

  // handshake: result register frees when empty or being taken
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_fire   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_FULL;
      abs_lim_r   <= ABS_LIMIT_RST;
      rel_lim_r   <= REL_LIMIT_RST;
      pkg_pers_r  <= PKG_PERSIST_RST;
      data_pers_r <= DATA_PERSIST_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CHECK_MODE:   mode_r      <= cfg_data[MODE_W-1:0];
        CFG_ABS_LIMIT:    abs_lim_r   <= cfg_data[ABS_LIM_W-1:0];
        CFG_REL_LIMIT:    rel_lim_r   <= cfg_data[REL_LIM_W-1:0];
        CFG_PKG_PERSIST:  pkg_pers_r  <= cfg_data[PERSIST_W-1:0];
        CFG_DATA_PERSIST: data_pers_r <= cfg_data[PERSIST_W-1:0];
        default: ;
      endcase
    end
  end

  // packet check
  svm_pkt #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_pkt (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_fire),
    .full        (axis_ctl.full),
    .timeout     (s1_data_r.timeout),
    .header_ok   (s1_data_r.header_ok),
    .checksum_ok (s1_data_r.checksum_ok),
    .payload_ok  (s1_data_r.payload_ok),
    .persist     (pkg_pers_r),
    .stat        (pkt_stat)
  );

  // modes 2 and 3 both mean no checks
  assign axis_ctl.fire      = s1_fire;
  assign axis_ctl.full      = (mode_r == MODE_FULL);
  assign axis_ctl.data_only = (mode_r == MODE_DATA);
  assign axis_ctl.pkt_bad   = pkt_stat.pkt_bad;

  assign ax_in[0]   = s1_data_r.sample_x;
  assign ax_in[1]   = s1_data_r.sample_y;
  assign ax_in[2]   = s1_data_r.sample_z;
  // switchover only affects the X fail flag
  assign ax_hold[0] = s1_data_r.switchover;
  assign ax_hold[1] = 1'b0;
  assign ax_hold[2] = 1'b0;

  for (genvar g = 0; g < AXES; g++) begin : g_axis
    svm_axis #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_axis (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (axis_ctl),
      .sw_hold   (ax_hold[g]),
      .sample    (ax_in[g]),
      .abs_limit (abs_lim_r),
      .rel_limit (rel_lim_r),
      .persist   (data_pers_r),
      .accepted  (ax_out[g]),
      .stat      (ax_stat[g])
    );
  end

  // sticky status, folded in only on a real beat
  always_comb begin
    perm_nxt   = perm_r;
    reject_nxt = reject_r;
    if (s1_fire) begin
      if (pkt_stat.pkg_fail) begin
        perm_nxt = perm_nxt | PERM_PKG_MASK;
      end
      if (ax_stat[0].fail_set) begin
        perm_nxt = perm_nxt | PERM_X;
      end
      if (ax_stat[1].fail_set) begin
        perm_nxt = perm_nxt | PERM_Y;
      end
      if (ax_stat[2].fail_set) begin
        perm_nxt = perm_nxt | PERM_Z;
      end
      if (pkt_stat.pkt_bad || ax_stat[0].replaced || ax_stat[1].replaced ||
          ax_stat[2].replaced) begin
        reject_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_data_nxt.accepted_x       = ax_out[0];
    out_data_nxt.accepted_y       = ax_out[1];
    out_data_nxt.accepted_z       = ax_out[2];
    // bit 3 reserved, reads zero
    out_data_nxt.instant_status   = {ax_stat[2].rate_exceed, ax_stat[1].rate_exceed,
                                     ax_stat[0].rate_exceed, 1'b0,
                                     ax_stat[2].abs_exceed, ax_stat[1].abs_exceed,
                                     ax_stat[0].abs_exceed};
    out_data_nxt.permanent_status = perm_nxt;
    out_data_nxt.package_bad      = pkt_stat.pkt_bad;
    out_data_nxt.reject_seen      = reject_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      perm_r      <= '0;
      reject_r    <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      perm_r      <= perm_nxt;
      reject_r    <= reject_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sticky failure bits never clear outside reset
  `SVM_ASSERT(a_perm_sticky, ((perm_r & $past(perm_r)) == $past(perm_r)), "permanent bit cleared")
  // a held result must not let the queued beat escape
  `SVM_ASSERT(a_no_drop, (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r, "beat lost")
  // a rejected packet always sets reject_seen
  `SVM_ASSERT(a_bad_marks, (out_valid_r && out_data_r.package_bad) |-> out_data_r.reject_seen, "reject_seen missing")
  // packets are only rejected under full checks
  `SVM_ASSERT(a_bad_mode, (s1_fire && pkt_stat.pkt_bad) |-> (mode_r == MODE_FULL), "bad packet outside full mode")
  // both stages come up empty after reset
  `SVM_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> (!out_valid_r && !s1_valid_r), "stage valid after reset")

endmodule
